### rtl/core/clex_pkg.sv
// ----------------------------------------------------------------------------
// clex_pkg
// Shared types, codes and tables of the character stream lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package clex_pkg;

  localparam int unsigned MAX_TOKEN_CHARS = 32;
  localparam int unsigned KW_COUNT        = 15;
  localparam int unsigned KW_MAX_LEN      = 6;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_CONST   = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_SEP     = 3'd4,
    KIND_ERROR   = 3'd5
  } clex_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_UNDER = 3'd2,
    MODE_DIGIT = 3'd3,
    MODE_LIT   = 3'd4
  } clex_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FRESH
  } clex_state_e;

  typedef struct packed {
    logic letter;
    logic digit;
    logic space;
    logic under;
    logic quote;
    logic oper;
    logic sep;
  } clex_class_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"e", "l", "s", "e", CH_NUL, CH_NUL},
    '{"v", "o", "i", "d", CH_NUL, CH_NUL},
    '{"r", "e", "t", "u", "r", "n"},
    '{"w", "h", "i", "l", "e", CH_NUL},
    '{"t", "h", "e", "n", CH_NUL, CH_NUL},
    '{"f", "o", "r", CH_NUL, CH_NUL, CH_NUL},
    '{"d", "o", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL},
    '{"c", "h", "a", "r", CH_NUL, CH_NUL},
    '{"d", "o", "u", "b", "l", "e"},
    '{"f", "l", "o", "a", "t", CH_NUL},
    '{"c", "a", "s", "e", CH_NUL, CH_NUL},
    '{"c", "i", "n", CH_NUL, CH_NUL, CH_NUL},
    '{"c", "o", "u", "t", CH_NUL, CH_NUL}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2,
    3'd3, 3'd4, 3'd6, 3'd5, 3'd4, 3'd3, 3'd4
  };

endpackage

`default_nettype wire

### rtl/core/clex_in_if.sv
// ----------------------------------------------------------------------------
// clex_in_if
// Input request channel: one source byte or an end-of-input flush.
// ----------------------------------------------------------------------------
`default_nettype none

interface clex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

### rtl/core/clex_out_if.sv
// ----------------------------------------------------------------------------
// clex_out_if
// Result request channel: one token character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface clex_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_char;
  logic [5:0] token_length;
  logic       last_of_token;

  modport source (output valid, output token_kind, output token_char,
                  output token_length, output last_of_token, input ready);
  modport sink   (input valid, input token_kind, input token_char,
                  input token_length, input last_of_token, output ready);
endinterface

`default_nettype wire

### rtl/core/clex_ram.sv
// ----------------------------------------------------------------------------
// clex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/clex_class.sv
// ----------------------------------------------------------------------------
// clex_class
// Character classifier and per-position keyword character match.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_class (
  input  logic [7:0]                  char_i,
  input  logic [2:0]                  pos_i,
  output clex_pkg::clex_class_t       cls_o,
  output logic [clex_pkg::KW_COUNT-1:0] kw_eq_o
);
  import clex_pkg::*;

  always_comb begin
    cls_o.letter = char_i inside {["A":"Z"], ["a":"z"]};
    cls_o.digit  = char_i inside {["0":"9"]};
    cls_o.space  = char_i inside {" ", CH_TAB, CH_CR, CH_LF};
    cls_o.under  = (char_i == "_");
    cls_o.quote  = char_i inside {CH_SQUOTE, CH_DQUOTE};
    cls_o.oper   = char_i inside {"+", "-", "*", "/", ">", "<", "=", "!"};
    cls_o.sep    = char_i inside {";", ",", "{", "}", "[", "]", "(", ")"};
  end

  // keyword i still matches if its character at this position equals the byte
  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      kw_eq_o[i] = (pos_i < 3'(KW_MAX_LEN)) && (KW_TEXT[i][pos_i] == char_i);
    end
  end

endmodule

`default_nettype wire

### rtl/core/char_stream_lexer_core.sv
// ----------------------------------------------------------------------------
// char_stream_lexer_core
// Byte-serial lexer: keywords, identifiers, constants, operators, separators.
// ----------------------------------------------------------------------------
// in_i carries one source byte per request, or an end-of-input flush.
// out_o carries one token character per request with kind, whole-token
// length and a last marker. Operators, separators and error bytes give one
// request, registered in the cycle after the byte is scanned.
// Token characters sit in a one-port-read RAM. A byte that ends a token
// starts a flush: the first character is read from the RAM's registered port
// into the output register, then one follows per cycle while out_o is ready.
// If the ending byte must itself be scanned, it is scanned in ST_FRESH after the last character.
// Inside a token one byte is taken per cycle while out_o is free; a token end
// blocks input until every character (one NUL request for an empty token) is
// read out through the single RAM read port and, if it must be, the ending byte is scanned.
// in_i.ready is low while a token is emitted and while out_o holds an
// untaken request; a stalled receiver simply freezes the block.
// Reset clears the scan state and the output; RAM contents are never read
// before being written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_lexer_core #(
  parameter int unsigned MaxTokenChars = clex_pkg::MAX_TOKEN_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clex_in_if.sink     in_i,
  clex_out_if.source  out_o
);
  import clex_pkg::*;

  localparam int unsigned Cw = $clog2(MaxTokenChars + 1);
  localparam int unsigned Aw = $clog2(MaxTokenChars);

  clex_state_e         state_q, state_d;
  clex_mode_e          mode_q, mode_d;
  logic [Cw-1:0]       cnt_q, cnt_d;
  logic [7:0]          quote_q, quote_d;
  logic [KW_COUNT-1:0] mask_q, mask_d;
  logic                pend_q, pend_d;
  logic [7:0]          pchar_q, pchar_d;
  clex_kind_e          tok_kind_q, tok_kind_d;
  logic [Cw-1:0]       tok_len_q, tok_len_d;
  logic [Aw-1:0]       rd_idx_q, rd_idx_d;

  logic                ov_q;
  logic [2:0]          okind_q;
  logic [7:0]          ochar_q;
  logic [5:0]          olen_q;
  logic                olast_q;

  logic                out_free, in_fire, cont, emit_last, kw_hit;
  logic [7:0]          fc;
  logic [2:0]          pos;
  clex_class_t         cls;
  logic [KW_COUNT-1:0] kw_eq, len_eq;
  clex_kind_e          flush_kind;

  logic                ram_we, ram_re;
  logic [Aw-1:0]       ram_waddr, ram_raddr;
  logic [7:0]          ram_rdata;

  logic                load, do_put, do_flush, do_fresh;
  clex_kind_e          ld_kind;
  logic [7:0]          ld_char;
  logic [5:0]          ld_len;
  logic                ld_last;

  assign out_free   = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign fc  = (state_q == ST_FRESH) ? pchar_q : in_i.char_code;
  assign pos = (cnt_q > Cw'(6)) ? 3'd7 : cnt_q[2:0];

  clex_class u_class (
    .char_i  (fc),
    .pos_i   (pos),
    .cls_o   (cls),
    .kw_eq_o (kw_eq)
  );

  clex_ram #(
    .Width (8),
    .Depth (MaxTokenChars)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (fc),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      len_eq[i] = (cnt_q == Cw'(KW_LEN[i]));
    end
    kw_hit = |(mask_q & len_eq);
  end

  always_comb begin
    case (mode_q)
      MODE_WORD:  cont = cls.letter;
      MODE_UNDER: cont = cls.letter || cls.digit || cls.under;
      MODE_DIGIT: cont = cls.digit;
      MODE_LIT:   cont = cls.letter || cls.digit;
      default:    cont = 1'b0;
    endcase
  end

  always_comb begin
    case (mode_q)
      MODE_WORD:  flush_kind = kw_hit ? KIND_KEYWORD : KIND_IDENT;
      MODE_UNDER: flush_kind = KIND_IDENT;
      default:    flush_kind = KIND_CONST;
    endcase
  end

  assign emit_last = (tok_len_q == '0) || ((Cw'(rd_idx_q) + Cw'(1)) == tok_len_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    quote_d    = quote_q;
    mask_d     = mask_q;
    pend_d     = pend_q;
    pchar_d    = pchar_q;
    tok_kind_d = tok_kind_q;
    tok_len_d  = tok_len_q;
    rd_idx_d   = rd_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_re     = 1'b0;
    ram_raddr  = rd_idx_q;
    load       = 1'b0;
    ld_kind    = KIND_ERROR;
    ld_char    = fc;
    ld_len     = 6'd1;
    ld_last    = 1'b1;
    do_put     = 1'b0;
    do_flush   = 1'b0;
    do_fresh   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.end_of_input) begin
            do_flush = (mode_q != MODE_IDLE);
          end else if (cont) begin
            do_put = 1'b1;
          end else if (mode_q == MODE_LIT && fc == quote_q) begin
            do_flush = 1'b1;
          end else if (mode_q != MODE_IDLE) begin
            do_flush = 1'b1;
            pend_d   = 1'b1;
            pchar_d  = fc;
          end else begin
            do_fresh = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = tok_kind_q;
          ld_char = (tok_len_q == '0) ? CH_NUL : ram_rdata;
          ld_len  = 6'(tok_len_q);
          ld_last = emit_last;
          if (emit_last) begin
            state_d = pend_q ? ST_FRESH : ST_IDLE;
          end else begin
            rd_idx_d  = rd_idx_q + Aw'(1);
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q + Aw'(1);
          end
        end
      end
      ST_FRESH: begin
        if (out_free) begin
          do_fresh = 1'b1;
          pend_d   = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_put && cnt_q < Cw'(MaxTokenChars)) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[Aw-1:0];
      cnt_d     = cnt_q + Cw'(1);
      if (mode_q == MODE_WORD) begin
        mask_d = mask_q & kw_eq;
      end
    end

    if (do_flush) begin
      tok_kind_d = flush_kind;
      tok_len_d  = cnt_q;
      rd_idx_d   = '0;
      ram_re     = 1'b1;
      ram_raddr  = '0;
      mode_d     = MODE_IDLE;
      cnt_d      = '0;
      state_d    = ST_EMIT;
    end

    if (do_fresh && !cls.space) begin
      cnt_d = '0;
      if (cls.letter || cls.under || cls.digit) begin
        ram_we = 1'b1;
        cnt_d  = Cw'(1);
        if (cls.letter) begin
          mode_d = MODE_WORD;
          mask_d = kw_eq;
        end else if (cls.under) begin
          mode_d = MODE_UNDER;
        end else begin
          mode_d = MODE_DIGIT;
        end
      end else if (cls.quote) begin
        mode_d  = MODE_LIT;
        quote_d = fc;
      end else begin
        load    = 1'b1;
        ld_kind = cls.oper ? KIND_OPER : (cls.sep ? KIND_SEP : KIND_ERROR);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_IDLE;
      cnt_q   <= '0;
      quote_q <= '0;
      mask_q  <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      quote_q <= quote_d;
      mask_q  <= mask_d;
      pend_q  <= pend_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pchar_q    <= pchar_d;
    tok_kind_q <= tok_kind_d;
    tok_len_q  <= tok_len_d;
    rd_idx_q   <= rd_idx_d;
    if (load) begin
      okind_q <= ld_kind;
      ochar_q <= ld_char;
      olen_q  <= ld_len;
      olast_q <= ld_last;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.token_kind    = okind_q;
  assign out_o.token_char    = ochar_q;
  assign out_o.token_length  = olen_q;
  assign out_o.last_of_token = olast_q;

endmodule

`default_nettype wire

### rtl/core/clex_core_chk.sv
// ----------------------------------------------------------------------------
// clex_core_chk
// Port-level checks of the lexer core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_core_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] token_kind,
  input logic [5:0] token_length,
  input logic       last_of_token
);
  import clex_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> token_kind <= KIND_ERROR)
    else $error("token kind out of range");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (token_kind == KIND_OPER || token_kind == KIND_SEP ||
                  token_kind == KIND_ERROR)
    |-> token_length == 6'd1 && last_of_token)
    else $error("single-character result malformed");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken while a result is stalled");

endmodule

bind char_stream_lexer_core clex_core_chk u_clex_core_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .token_kind    (out_o.token_kind),
  .token_length  (out_o.token_length),
  .last_of_token (out_o.last_of_token)
);

`default_nettype wire
